/* hdl/srsw_pkg.sv */
// shared types, codes and constants for the selective-repeat sender window
// no dependencies; compiled first
package srsw_pkg;

  // fixed field widths
  localparam int SEQ_W          = 4;
  localparam int PAYLOAD_BITS   = 32;
  localparam int SEQ_MAX        = 16;
  localparam int MAX_WINDOW_DEF = 8;
  localparam int WLEN_W         = 4;
  localparam int SCNT_W         = 5;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  // operation codes
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [2:0] ST_SENT    = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_ACKED   = 3'd2;
  localparam logic [2:0] ST_CORRUPT = 3'd3;
  localparam logic [2:0] ST_DUP     = 3'd4;
  localparam logic [2:0] ST_RESENT  = 3'd5;
  localparam logic [2:0] ST_BAD     = 3'd6;

  // timer actions
  localparam logic [1:0] TM_NONE    = 2'd0;
  localparam logic [1:0] TM_START   = 2'd1;
  localparam logic [1:0] TM_STOP    = 2'd2;
  localparam logic [1:0] TM_RESTART = 2'd3;

  // register indexes (address bit 2)
  localparam logic CFG_WINDOW_LENGTH  = 1'b0;
  localparam logic CFG_SEQUENCE_COUNT = 1'b1;

  // register reset values
  localparam logic [WLEN_W-1:0] WLEN_RST = 4'd4;
  localparam logic [SCNT_W-1:0] SCNT_RST = 5'd8;

  typedef struct packed {
    logic [1:0]              operation;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        sequence_number;
    logic                    checksum_ok;
  } srsw_req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic                    transmit_valid;
    logic [SEQ_W-1:0]        transmit_seq;
    logic [PAYLOAD_BITS-1:0] transmit_payload;
    logic [1:0]              timer_action;
    logic [SEQ_W-1:0]        timer_seq;
    logic                    window_full;
    logic [SEQ_W-1:0]        window_base;
  } srsw_res_t;

  typedef struct packed {
    logic [WLEN_W-1:0] window_length;
    logic [SCNT_W-1:0] sequence_count;
  } srsw_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic reduce;
    logic exec;
    logic slide;
    logic finish;
  } srsw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reduce_done;
    logic go_slide;
    logic slide_done;
  } srsw_sts_t;

endpackage

/* hdl/srsw_cfg.sv */
// configuration registers behind an apb-style port
// depends on srsw_pkg
module srsw_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsw_pkg::APB_AW-1:0]   paddr,
  input  logic [srsw_pkg::APB_DW-1:0]   pwdata,
  output logic [srsw_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output srsw_pkg::srsw_cfg_t           cfg_o
);
  import srsw_pkg::*;

  logic [WLEN_W-1:0] wlen_q;
  logic [SCNT_W-1:0] scnt_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RST;
      scnt_q <= SCNT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        CFG_WINDOW_LENGTH:  wlen_q <= pwdata[WLEN_W-1:0];
        CFG_SEQUENCE_COUNT: scnt_q <= pwdata[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_WINDOW_LENGTH:  prdata = {{(APB_DW-WLEN_W){1'b0}}, wlen_q};
      CFG_SEQUENCE_COUNT: prdata = {{(APB_DW-SCNT_W){1'b0}}, scnt_q};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.window_length  = wlen_q;
  assign cfg_o.sequence_count = scnt_q;

endmodule

/* hdl/srsw_ctrl.sv */
// sequencing state machine: reduce, execute, slide, respond
// depends on srsw_pkg
module srsw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  srsw_pkg::srsw_sts_t sts_i,
  output srsw_pkg::srsw_cmd_t cmd_o
);
  import srsw_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SLIDE  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.reduce = 1'b1;
        if (sts_i.reduce_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.go_slide ? S_SLIDE : S_DONE;
      end
      S_SLIDE: begin
        cmd_o.slide = 1'b1;
        if (sts_i.slide_done) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* hdl/srsw_dp.sv */
// window datapath: sequence reduction, slot store, ack flags, result register
// depends on srsw_pkg
module srsw_dp #(
  parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srsw_pkg::srsw_cfg_t cfg_i,
  input  srsw_pkg::srsw_req_t req_i,
  input  srsw_pkg::srsw_cmd_t cmd_i,
  output srsw_pkg::srsw_sts_t sts_o,
  output logic                done_o,
  output srsw_pkg::srsw_res_t res_o
);
  import srsw_pkg::*;

  localparam int OW   = $clog2(MAX_WINDOW + 1);
  localparam int SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUMW = ((SW > SEQ_W) ? SW : SEQ_W) + 1;

  // request latched at accept
  logic [1:0]              op_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic                    ck_q;
  logic [SEQ_W-1:0]        rseq_q, rbase_q, rnext_q;

  // window state
  logic [SEQ_W-1:0]        base_q, next_q;
  logic [OW-1:0]           occ_q;
  logic [SW-1:0]           head_q;
  logic [MAX_WINDOW-1:0]   acked_q;
  logic [2:0]              status_q;
  logic                    ack_taken_q;

  // payload memory
  logic [PAYLOAD_BITS-1:0] mem [MAX_WINDOW];
  logic [PAYLOAD_BITS-1:0] rd_q;
  logic                    mem_we;

  srsw_res_t               res_q, res_d;
  logic                    done_q;

  logic [OW-1:0]           wl_eff;
  logic [SCNT_W-1:0]       sc_eff;
  logic                    ge_seq, ge_base, ge_next;
  logic [SCNT_W-1:0]       off_sum, off_red;
  logic [SEQ_W-1:0]        offset;
  logic                    hit;
  logic [SUMW-1:0]         slot_sum, slot_red, ins_sum, ins_red;
  logic [SW-1:0]           slot, ins_slot, head_inc;
  logic                    slot_ok, slot_acked;
  logic                    send_ok;
  logic [SCNT_W-1:0]       next_sum, base_sum;
  logic [SEQ_W-1:0]        next_inc, base_inc;

  // saturated configuration
  always_comb begin
    if (cfg_i.window_length == '0) begin
      wl_eff = OW'(1);
    end else if (cfg_i.window_length > MAX_WINDOW) begin
      wl_eff = OW'(MAX_WINDOW);
    end else begin
      wl_eff = OW'(cfg_i.window_length);
    end
    if (cfg_i.sequence_count < SCNT_W'(2)) begin
      sc_eff = SCNT_W'(2);
    end else if (cfg_i.sequence_count > SCNT_W'(SEQ_MAX)) begin
      sc_eff = SCNT_W'(SEQ_MAX);
    end else begin
      sc_eff = cfg_i.sequence_count;
    end
  end

  // one subtract step per cycle for each value still at or above the modulus
  assign ge_seq  = {1'b0, rseq_q}  >= sc_eff;
  assign ge_base = {1'b0, rbase_q} >= sc_eff;
  assign ge_next = {1'b0, rnext_q} >= sc_eff;

  // distance from base, then the slot it maps to
  assign off_sum = {1'b0, rseq_q} + sc_eff - {1'b0, rbase_q};
  assign off_red = (off_sum >= sc_eff) ? (off_sum - sc_eff) : off_sum;
  assign offset  = off_red[SEQ_W-1:0];
  assign hit     = (SUMW'(offset) < SUMW'(occ_q));

  assign slot_sum   = SUMW'(head_q) + SUMW'(offset);
  assign slot_red   = (slot_sum >= SUMW'(MAX_WINDOW)) ? (slot_sum - SUMW'(MAX_WINDOW))
                                                      : slot_sum;
  assign slot_ok    = (slot_red < SUMW'(MAX_WINDOW));
  assign slot       = slot_red[SW-1:0];
  assign slot_acked = slot_ok ? acked_q[slot] : 1'b1;

  assign ins_sum  = SUMW'(head_q) + SUMW'(occ_q);
  assign ins_red  = (ins_sum >= SUMW'(MAX_WINDOW)) ? (ins_sum - SUMW'(MAX_WINDOW)) : ins_sum;
  assign ins_slot = ins_red[SW-1:0];
  assign send_ok  = (occ_q < wl_eff);

  assign head_inc = (head_q == SW'(MAX_WINDOW - 1)) ? '0 : (head_q + SW'(1));
  assign next_sum = {1'b0, rnext_q} + SCNT_W'(1);
  assign next_inc = (next_sum == sc_eff) ? '0 : next_sum[SEQ_W-1:0];
  assign base_sum = {1'b0, base_q} + SCNT_W'(1);
  assign base_inc = (base_sum == sc_eff) ? '0 : base_sum[SEQ_W-1:0];

  assign sts_o.reduce_done = !(ge_seq | ge_base | ge_next);
  assign sts_o.go_slide    = (op_q == OP_ACK) & ck_q & hit & !slot_acked;
  assign sts_o.slide_done  = (occ_q == '0) | !acked_q[head_q];

  assign mem_we = cmd_i.exec & (op_q == OP_SEND) & send_ok;

  // request and working copies
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= req_i.operation;
      pay_q   <= req_i.payload;
      ck_q    <= req_i.checksum_ok;
      rseq_q  <= req_i.sequence_number;
      rbase_q <= base_q;
      rnext_q <= next_q;
    end else if (cmd_i.reduce) begin
      if (ge_seq)  rseq_q  <= rseq_q  - sc_eff[SEQ_W-1:0];
      if (ge_base) rbase_q <= rbase_q - sc_eff[SEQ_W-1:0];
      if (ge_next) rnext_q <= rnext_q - sc_eff[SEQ_W-1:0];
    end
  end

  // window control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      next_q      <= '0;
      occ_q       <= '0;
      head_q      <= '0;
      acked_q     <= '0;
      status_q    <= ST_BAD;
      ack_taken_q <= 1'b0;
    end else if (cmd_i.load) begin
      ack_taken_q <= 1'b0;
    end else if (cmd_i.exec) begin
      ack_taken_q <= sts_o.go_slide;
      case (op_q)
        OP_SEND: begin
          if (send_ok) begin
            acked_q[ins_slot] <= 1'b0;
            occ_q             <= occ_q + OW'(1);
            next_q            <= next_inc;
            status_q          <= ST_SENT;
          end else begin
            status_q <= ST_FULL;
          end
        end
        OP_ACK: begin
          if (!ck_q) begin
            status_q <= ST_CORRUPT;
          end else if (hit && !slot_acked) begin
            acked_q[slot] <= 1'b1;
            base_q        <= rbase_q;
            status_q      <= ST_ACKED;
          end else begin
            status_q <= ST_DUP;
          end
        end
        OP_TIMEOUT: begin
          status_q <= hit ? ST_RESENT : ST_BAD;
        end
        default: begin
          status_q <= ST_BAD;
        end
      endcase
    end else if (cmd_i.slide && !sts_o.slide_done) begin
      // pop one acknowledged slot from the head
      acked_q[head_q] <= 1'b0;
      head_q          <= head_inc;
      occ_q           <= occ_q - OW'(1);
      base_q          <= base_inc;
    end
  end

  // payload store, registered read at the addressed slot
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[ins_slot] <= pay_q;
    rd_q <= mem[slot];
  end

  always_comb begin
    res_d             = '0;
    res_d.status      = status_q;
    res_d.window_full = (occ_q >= wl_eff);
    res_d.window_base = ack_taken_q ? base_q : rbase_q;
    case (status_q)
      ST_SENT: begin
        res_d.transmit_valid   = 1'b1;
        res_d.transmit_seq     = rnext_q;
        res_d.transmit_payload = pay_q;
        res_d.timer_action     = TM_START;
        res_d.timer_seq        = rnext_q;
      end
      ST_ACKED: begin
        res_d.timer_action = TM_STOP;
        res_d.timer_seq    = rseq_q;
      end
      ST_RESENT: begin
        res_d.transmit_valid   = 1'b1;
        res_d.transmit_seq     = rseq_q;
        res_d.transmit_payload = rd_q;
        res_d.timer_action     = TM_RESTART;
        res_d.timer_seq        = rseq_q;
      end
      default: begin
        res_d.timer_action = TM_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  // occupancy stays within the slot store
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(MAX_WINDOW))
    else $error("occupancy beyond window store");

  // an empty window holds no stale acknowledged flags
  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == '0 |-> acked_q == '0)
    else $error("acknowledged flag left in empty window");

  // each slide step removes exactly one entry
  a_slide_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.slide && !sts_o.slide_done |=> occ_q == $past(occ_q) - OW'(1))
    else $error("slide step did not pop one entry");

  // nothing handed to the network carries a stray payload
  a_quiet_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !res_q.transmit_valid |-> res_q.transmit_payload == '0)
    else $error("payload present without transmit");
`endif

endmodule

/* hdl/selective_repeat_sender_window.sv */
// top level of the selective-repeat sender window
// depends on srsw_pkg, srsw_cfg, srsw_ctrl, srsw_dp
//
// Selective-repeat ARQ sender window. A request (start high while busy is
// low) carries one operation: send stores the payload in the next free slot,
// numbers it and asks for a timer start; ack marks an outstanding slot and
// slides the base past leading acknowledged slots; timeout resends a stored
// packet and asks for a timer restart. Exactly one result per request appears
// on res_o for a single cycle with done_o high; the receiver cannot stall it,
// so it must capture the result in that cycle. After the accepting edge a
// request first reduces the incoming, base and next sequence numbers below
// the configured modulus by subtract steps, then executes, then, for an
// accepted ack only, pops the leading acknowledged slots, and then registers
// its result; busy drops in the cycle done_o is shown, so the next request
// may be accepted then. The payload store is a MAX_WINDOW-entry memory with
// one write and one registered read port; its contents are undefined until
// written and need no clearing after reset. Registers: window_length at byte
// 0 (saturated to 1..MAX_WINDOW), sequence_count at byte 4 (saturated to
// 2..16); write them only while the block is idle.
module selective_repeat_sender_window #(
  parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  srsw_pkg::srsw_req_t           req_i,
  // result channel
  output logic                          done_o,
  output srsw_pkg::srsw_res_t           res_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsw_pkg::APB_AW-1:0]   paddr,
  input  logic [srsw_pkg::APB_DW-1:0]   pwdata,
  output logic [srsw_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import srsw_pkg::*;

  srsw_cfg_t cfg;
  srsw_cmd_t cmd;
  srsw_sts_t sts;
  logic      ctrl_busy;

  // register file for window length and sequence modulus
  srsw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: accept, reduce, execute, slide, respond
  srsw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (ctrl_busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // window state, payload memory and result register
  srsw_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (res_o)
  );

  assign busy = ctrl_busy;

endmodule
